[src/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, opcodes, status codes,
// request/response payload types and the control word of the datapath cells.
// No dependencies.
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int DW        = 2 * WORD_BITS;
   localparam int CELL_BITS = 2;
   localparam int N_CELLS   = DW / CELL_BITS;
   localparam int CNT_BITS  = $clog2(DW);

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_SCALE = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   typedef enum logic [2:0] {
      C_HOLD,
      C_LOAD,
      C_SHR,
      C_SUB,
      C_MOVE,
      C_SHLW,
      C_DIV
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        sh_u;
      logic        sh_v;
      logic        u_lt_v;
      logic        from_v;
      logic        take;
   } cell_ctrl_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         status;
   } rsp_type;

endpackage

[src/rau_cell.sv]
// One slice of the GCD / divide datapath: holds CELL_BITS of registers u, v, w.
// Borrows and shift bits pass to neighbor slices. Depends on rau_pkg.
module rau_cell import rau_pkg::*; (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [CELL_BITS-1:0] ld_u,
   input  logic [CELL_BITS-1:0] ld_v,
   input  logic                 u_hi_in,
   input  logic                 v_hi_in,
   input  logic                 u_lo_in,
   input  logic                 v_lo_in,
   input  logic                 w_lo_in,
   input  logic                 b_uv_in,
   input  logic                 b_vu_in,
   input  logic                 b_dw_in,
   output logic                 b_uv_out,
   output logic                 b_vu_out,
   output logic                 b_dw_out,
   output logic [CELL_BITS-1:0] u_q,
   output logic [CELL_BITS-1:0] v_q,
   output logic [CELL_BITS-1:0] w_q
);

   logic [CELL_BITS-1:0] u_ff, u_in, v_ff, v_in, w_ff, w_in;
   logic [CELL_BITS-1:0] us;
   logic [CELL_BITS:0]   d_uv, d_vu, d_dw;

   always_comb begin
      us   = {u_ff[CELL_BITS-2:0], u_lo_in};
      d_uv = {1'b0, u_ff} - {1'b0, v_ff} - (CELL_BITS+1)'(b_uv_in);
      d_vu = {1'b0, v_ff} - {1'b0, u_ff} - (CELL_BITS+1)'(b_vu_in);
      d_dw = {1'b0, us} - {1'b0, w_ff} - (CELL_BITS+1)'(b_dw_in);
      u_in = u_ff;
      v_in = v_ff;
      w_in = w_ff;
      case (ctrl.op)
         C_LOAD: begin
            u_in = ld_u;
            v_in = ld_v;
         end
         C_SHR: begin
            if (ctrl.sh_u) u_in = {u_hi_in, u_ff[CELL_BITS-1:1]};
            if (ctrl.sh_v) v_in = {v_hi_in, v_ff[CELL_BITS-1:1]};
         end
         C_SUB: begin
            if (ctrl.u_lt_v) v_in = d_vu[CELL_BITS-1:0];
            else u_in = d_uv[CELL_BITS-1:0];
         end
         C_MOVE: begin
            w_in = ctrl.from_v ? v_ff : u_ff;
         end
         C_SHLW: begin
            w_in = {w_ff[CELL_BITS-2:0], w_lo_in};
         end
         C_DIV: begin
            v_in = {v_ff[CELL_BITS-2:0], v_lo_in};
            u_in = ctrl.take ? d_dw[CELL_BITS-1:0] : us;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign b_uv_out = d_uv[CELL_BITS];
   assign b_vu_out = d_vu[CELL_BITS];
   assign b_dw_out = d_dw[CELL_BITS];
   assign u_q      = u_ff;
   assign v_q      = v_ff;
   assign w_q      = w_ff;

endmodule

[src/rational_arith_unit.sv]
// Rational add/sub/mul/div/scale with binary-GCD reduction over a row of rau_cell slices.
// Steps: multiply, combine, binary-GCD loop, left shifts of the GCD, bit-serial divide of the
// numerator and then of the denominator by the GCD, and the output register write.
// One request at a time; the next is taken once the result sits in the output register.
// Synchronous active-high reset clears the controller and response valid only.
// Depends on rau_pkg and rau_cell.
module rational_arith_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL  = 9'b000000010,
      S_COMB = 9'b000000100,
      S_GCD  = 9'b000001000,
      S_SHL  = 9'b000010000,
      S_DIVN = 9'b000100000,
      S_LDD  = 9'b001000000,
      S_DIVD = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   localparam logic [DW-1:0] HALF = DW'(1) << (WORD_BITS - 1);

   function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
      mag_of = x[WORD_BITS-1] ? (~x + 1'b1) : x;
   endfunction

   state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic an_neg_ff, an_neg_in, ad_neg_ff, ad_neg_in, bn_neg_ff, bn_neg_in, bd_neg_ff, bd_neg_in;
   logic [WORD_BITS-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [DW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [DW-1:0] n_mag_ff, n_mag_in, d_mag_ff, d_mag_in, nq_ff, nq_in;
   logic num_neg_ff, num_neg_in, err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   cell_ctrl_type ctrl;
   logic [DW-1:0] ld_u, ld_v, u_bus, v_bus, w_bus;
   logic [N_CELLS:0] b_uv, b_vu, b_dw;
   logic [DW-1:0] u_shr, v_shr, u_shl, v_shl, w_shl;

   logic [WORD_BITS-1:0] mx, my;
   logic [DW-1:0] prod, sum_mag, num_mag;
   logic is_mul, is_div, is_scale, zden, x_neg, t_neg, sum_neg, num_neg, den_neg;
   logic res_neg, over;
   logic [DW-1:0] n_full;

   assign u_shr = {1'b0, u_bus[DW-1:1]};
   assign v_shr = {1'b0, v_bus[DW-1:1]};
   assign u_shl = {u_bus[DW-2:0], v_bus[DW-1]};
   assign v_shl = {v_bus[DW-2:0], ctrl.take};
   assign w_shl = {w_bus[DW-2:0], 1'b0};
   assign b_uv[0] = 1'b0;
   assign b_vu[0] = 1'b0;
   assign b_dw[0] = 1'b0;

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      rau_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .ld_u     (ld_u[i*CELL_BITS +: CELL_BITS]),
         .ld_v     (ld_v[i*CELL_BITS +: CELL_BITS]),
         .u_hi_in  (u_shr[i*CELL_BITS + CELL_BITS - 1]),
         .v_hi_in  (v_shr[i*CELL_BITS + CELL_BITS - 1]),
         .u_lo_in  (u_shl[i*CELL_BITS]),
         .v_lo_in  (v_shl[i*CELL_BITS]),
         .w_lo_in  (w_shl[i*CELL_BITS]),
         .b_uv_in  (b_uv[i]),
         .b_vu_in  (b_vu[i]),
         .b_dw_in  (b_dw[i]),
         .b_uv_out (b_uv[i+1]),
         .b_vu_out (b_vu[i+1]),
         .b_dw_out (b_dw[i+1]),
         .u_q      (u_bus[i*CELL_BITS +: CELL_BITS]),
         .v_q      (v_bus[i*CELL_BITS +: CELL_BITS]),
         .w_q      (w_bus[i*CELL_BITS +: CELL_BITS])
      );
   end

   always_comb begin
      is_mul   = (op_ff == OP_MUL);
      is_div   = (op_ff == OP_DIV);
      is_scale = (op_ff == OP_SCALE);

      case (cnt_ff[1:0])
         2'd0: begin
            mx = an_ff;
            my = (is_mul || is_scale) ? bn_ff : bd_ff;
         end
         2'd1: begin
            mx = ad_ff;
            my = is_div ? bn_ff : (is_scale ? WORD_BITS'(1) : bd_ff);
         end
         default: begin
            mx = bn_ff;
            my = ad_ff;
         end
      endcase
      prod = DW'(mx) * DW'(my);

      if (is_div) zden = (ad_ff == '0) || (bd_ff == '0) || (bn_ff == '0);
      else if (is_scale) zden = (ad_ff == '0);
      else zden = (ad_ff == '0) || (bd_ff == '0);

      x_neg = an_neg_ff ^ bd_neg_ff;
      t_neg = bn_neg_ff ^ ad_neg_ff ^ (op_ff == OP_SUB);
      if (x_neg == t_neg) begin
         sum_mag = p0_ff + p2_ff;
         sum_neg = x_neg;
      end else if (p0_ff >= p2_ff) begin
         sum_mag = p0_ff - p2_ff;
         sum_neg = x_neg;
      end else begin
         sum_mag = p2_ff - p0_ff;
         sum_neg = t_neg;
      end

      if (is_mul || is_scale) begin
         num_mag = p0_ff;
         num_neg = an_neg_ff ^ bn_neg_ff;
      end else if (is_div) begin
         num_mag = p0_ff;
         num_neg = an_neg_ff ^ bd_neg_ff;
      end else begin
         num_mag = sum_mag;
         num_neg = sum_neg;
      end
      if (is_div) den_neg = ad_neg_ff ^ bn_neg_ff;
      else if (is_scale) den_neg = ad_neg_ff;
      else den_neg = ad_neg_ff ^ bd_neg_ff;

      res_neg = num_neg_ff && (nq_ff != '0);
      over = (v_bus > HALF - 1'b1) ||
             (res_neg ? (nq_ff > HALF) : (nq_ff > HALF - 1'b1));
      n_full = res_neg ? (~nq_ff + 1'b1) : nq_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      an_neg_in    = an_neg_ff;
      ad_neg_in    = ad_neg_ff;
      bn_neg_in    = bn_neg_ff;
      bd_neg_in    = bd_neg_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      n_mag_in     = n_mag_ff;
      d_mag_in     = d_mag_ff;
      nq_in        = nq_ff;
      num_neg_in   = num_neg_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '{op: C_HOLD, sh_u: 1'b0, sh_v: 1'b0, u_lt_v: b_uv[N_CELLS],
                       from_v: 1'b0, take: ~b_dw[N_CELLS]};
      ld_u         = '0;
      ld_v         = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               an_neg_in = req_data.a_num[WORD_BITS-1];
               ad_neg_in = req_data.a_den[WORD_BITS-1];
               bn_neg_in = req_data.b_num[WORD_BITS-1];
               bd_neg_in = req_data.b_den[WORD_BITS-1];
               an_in     = mag_of(req_data.a_num[WORD_BITS-1:0]);
               ad_in     = mag_of(req_data.a_den[WORD_BITS-1:0]);
               bn_in     = mag_of(req_data.b_num[WORD_BITS-1:0]);
               bd_in     = mag_of(req_data.b_den[WORD_BITS-1:0]);
               cnt_in    = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    p0_in = prod;
               2'd1:    p1_in = prod;
               default: p2_in = prod;
            endcase
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_in   = '0;
               state_in = S_COMB;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_COMB: begin
            if (zden) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               err_in     = 1'b0;
               n_mag_in   = num_mag;
               d_mag_in   = p1_ff;
               num_neg_in = num_neg ^ den_neg;
               k_in       = '0;
               ctrl.op    = C_LOAD;
               ld_u       = num_mag;
               ld_v       = p1_ff;
               state_in   = S_GCD;
            end
         end
         S_GCD: begin
            if (u_bus == '0) begin
               ctrl.op     = C_MOVE;
               ctrl.from_v = 1'b1;
               state_in    = S_SHL;
            end else if (v_bus == '0) begin
               ctrl.op  = C_MOVE;
               state_in = S_SHL;
            end else if (!u_bus[0] || !v_bus[0]) begin
               ctrl.op   = C_SHR;
               ctrl.sh_u = !u_bus[0];
               ctrl.sh_v = !v_bus[0];
               if (!u_bus[0] && !v_bus[0]) k_in = k_ff + 1'b1;
            end else begin
               ctrl.op = C_SUB;
            end
         end
         S_SHL: begin
            if (k_ff == '0) begin
               ctrl.op  = C_LOAD;
               ld_v     = n_mag_ff;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else begin
               ctrl.op = C_SHLW;
               k_in    = k_ff - 1'b1;
            end
         end
         S_DIVN: begin
            ctrl.op = C_DIV;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DW - 1)) state_in = S_LDD;
         end
         S_LDD: begin
            nq_in    = v_bus;
            ctrl.op  = C_LOAD;
            ld_v     = d_mag_ff;
            cnt_in   = '0;
            state_in = S_DIVD;
         end
         S_DIVD: begin
            ctrl.op = C_DIV;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DW - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in = '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
               end else if (over) begin
                  rsp_data_in = '{res_num: '0, res_den: '0, status: ST_RANGE};
               end else begin
                  rsp_data_in.res_num = 32'($signed(n_full[WORD_BITS-1:0]));
                  rsp_data_in.res_den = 31'(v_bus[WORD_BITS-2:0]);
                  rsp_data_in.status  = ST_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      an_neg_ff  <= an_neg_in;
      ad_neg_ff  <= ad_neg_in;
      bn_neg_ff  <= bn_neg_in;
      bd_neg_ff  <= bd_neg_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      cnt_ff     <= cnt_in;
      k_ff       <= k_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      n_mag_ff   <= n_mag_in;
      d_mag_ff   <= d_mag_in;
      nq_ff      <= nq_in;
      num_neg_ff <= num_neg_in;
      err_ff     <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |->
         (rsp_data_ff.res_num == '0 && rsp_data_ff.res_den == '0))
      else $error("nonzero status with nonzero result fields");

   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_OK) |-> (rsp_data_ff.res_den != '0))
      else $error("ok result with zero denominator");

   a_rem_lt_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVN || state_ff == S_DIVD) |-> (u_bus < w_bus))
      else $error("divide remainder not below divisor");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_GCD && u_bus == '0 && v_bus == '0))
      else $error("gcd operands both zero");

endmodule

[sim/tb_top.sv]
// Testbench for rational_arith_unit: random and directed fraction requests,
// results predicted in-bench and checked in order by a scoreboard class.
// Depends on rau_pkg and the rational_arith_unit RTL.
module tb_top import rau_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   class frac_scoreboard;
      rsp_type pending[$];
      int      errors;

      function automatic void sign_mag(input logic signed [31:0] v, output logic neg,
                                       output logic [63:0] mag);
         neg = v[31];
         mag = v[31] ? 64'(-$signed(65'(v))) : 64'(v);
      endfunction

      function automatic rsp_type reduce(input req_type r);
         logic an_s, ad_s, bn_s, bd_s, n_s, d_s, t_s, u_s;
         logic [63:0] an, ad, bn, bd, n, d, t, u, g, x, y, rem;
         logic [1:0] st;
         rsp_type o;
         sign_mag(r.a_num, an_s, an);
         sign_mag(r.a_den, ad_s, ad);
         sign_mag(r.b_num, bn_s, bn);
         sign_mag(r.b_den, bd_s, bd);
         st = ST_OK;
         case (r.opcode)
            OP_MUL: begin
               n_s = an_s ^ bn_s; n = an * bn; d_s = ad_s ^ bd_s; d = ad * bd;
               if (ad == 0 || bd == 0) st = ST_ZERO_DEN;
            end
            OP_DIV: begin
               n_s = an_s ^ bd_s; n = an * bd; d_s = ad_s ^ bn_s; d = ad * bn;
               if (ad == 0 || bd == 0 || bn == 0) st = ST_ZERO_DEN;
            end
            OP_SCALE: begin
               n_s = an_s ^ bn_s; n = an * bn; d_s = ad_s; d = ad;
               if (ad == 0) st = ST_ZERO_DEN;
            end
            default: begin
               t_s = bn_s ^ ad_s; t = bn * ad;
               if (r.opcode == OP_SUB) t_s = !t_s;
               u_s = an_s ^ bd_s; u = an * bd;
               if (u_s == t_s) begin n_s = u_s; n = u + t; end
               else if (u >= t) begin n_s = u_s; n = u - t; end
               else begin n_s = t_s; n = t - u; end
               d_s = ad_s ^ bd_s; d = ad * bd;
               if (ad == 0 || bd == 0) st = ST_ZERO_DEN;
            end
         endcase
         o = '0;
         if (st == ST_OK) begin
            if (d_s) n_s = !n_s;
            x = n; y = d;
            while (y != 0) begin rem = x % y; x = y; y = rem; end
            g = x;
            n = n / g; d = d / g;
            if (n == 0) n_s = 0;
            if (d > 64'h7FFF_FFFF) st = ST_RANGE;
            else if (n_s ? n > 64'h8000_0000 : n > 64'h7FFF_FFFF) st = ST_RANGE;
            if (st == ST_OK) begin
               o.res_num = n_s ? -n[31:0] : n[31:0];
               o.res_den = d[30:0];
            end
         end
         o.status = st;
         return o;
      endfunction

      function void note_request(input req_type r);
         pending.push_back(reduce(r));
      endfunction

      function void check_result(input rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%t unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.res_num !== exp_r.res_num || got.res_den !== exp_r.res_den ||
             got.status !== exp_r.status) begin
            $display("%t mismatch: expected num %0d den %0d st %0d, got num %0d den %0d st %0d",
                     $realtime, exp_r.res_num, exp_r.res_den, exp_r.status,
                     got.res_num, got.res_den, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   frac_scoreboard sb;
   int      idle_cycles;
   bit      stim_done;

   rational_arith_unit DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return -$urandom_range(0, 20);
         2: return $urandom_range(0, 65535);
         3: return -$urandom_range(0, 65535);
         4: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_req(input logic [2:0] op, input logic [31:0] an, ad, bn, bd);
      req_type r;
      int      gap;
      gap = $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      r.opcode = op; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] mx, mn;
      sb = new();
      reset = 1; req_valid = 0; req_data = '0; stim_done = 0;
      mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_req(OP_ADD, 1, 2, 1, 3);
      send_req(OP_SUB, 1, 2, 1, 2);
      send_req(OP_MUL, -3, 4, 2, -9);
      send_req(OP_DIV, 5, 7, 10, 21);
      send_req(OP_SCALE, 3, 8, 4, 0);
      send_req(OP_ADD, 1, 0, 1, 2);
      send_req(OP_MUL, 1, 2, 1, 0);
      send_req(OP_DIV, 1, 2, 0, 3);
      send_req(OP_SCALE, 1, 0, 5, 1);
      send_req(OP_MUL, mx, 1, mx, 1);
      send_req(OP_MUL, mn, 1, 1, 1);
      send_req(OP_MUL, mn, 1, -1, 1);
      send_req(OP_DIV, 1, mn, 1, 1);
      send_req(OP_DIV, 1, mn, -1, 1);
      send_req(OP_ADD, mn, mn, mx, mx);
      send_req(OP_SUB, mx, mn, mn, mx);
      send_req(OP_ADD, 0, -5, 0, 7);
      send_req(OP_SCALE, mn, -1, -1, mn);
      send_req(3'd5, 1, 3, 1, 6);
      send_req(3'd6, -1, 3, 1, 6);
      send_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, mx, mn);
      drain();
      for (int i = 0; i < 1600; i++) begin
         send_req($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                  rand_word(), rand_word(), rand_word(), rand_word());
         if (i == 800) drain();
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            rsp_ready <= 0;
         end else if (!rsp_ready && !reset) begin
            repeat ($urandom_range(0, 19)) @(posedge clock);
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 20000) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
